// ===== hw/rtl/stf_pkg.sv =====
`default_nettype none
package stf_pkg;

  localparam logic [1:0] KIND_MAC  = 2'd0;
  localparam logic [1:0] KIND_IPV4 = 2'd1;
  localparam logic [1:0] KIND_IPV6 = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  localparam logic [7:0]  IPV4_FULL_LEN  = 8'd32;
  localparam logic [7:0]  IPV6_FULL_LEN  = 8'd128;
  localparam logic [31:0] WT_DFLT_VAL    = 32'd10;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture record
    OP_HEX_BYTE,  // MAC byte, two chars
    OP_DEC_LOAD,  // load dec converter
    OP_DEC_STEP,  // one digit extraction
    OP_DEC_EMIT,  // emit stored digits
    OP_HEX_GROUP, // IPv6 group digits
    OP_CHAR,      // emit literal char
    OP_FIND_RUN   // zero run scan step
  } op_t;

  typedef enum logic [1:0] {
    DSRC_OCTET,
    DSRC_PLEN,
    DSRC_WEIGHT
  } dsrc_t;

  typedef struct packed {
    op_t        op;
    dsrc_t      dsrc;
    logic [7:0] lit;
    logic [2:0] idx;    // byte / octet / group index
    logic       emit;   // char offered this cycle; steps emit position
  } dp_cmd_t;

  typedef struct packed {
    logic       char_busy;  // multi-char op not finished
    logic       dec_done;   // conversion finished
    logic [1:0] kind;
    logic       plen_dflt4;
    logic       plen_dflt6;
    logic       wt_dflt;
    logic       wt_neg;
    logic [2:0] run_at;
    logic [3:0] run_len;
  } dp_sts_t;

  function automatic logic [7:0] hex_ch(input logic [3:0] d);
    hex_ch = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stf_datapath.sv =====
`default_nettype none
module stf_datapath (
  input  wire logic            clk,
  input  wire logic [1:0]      in_subnet_kind,
  input  wire logic [63:0]     in_addr_high,
  input  wire logic [63:0]     in_addr_low,
  input  wire logic [7:0]      in_prefix_len,
  input  wire logic [31:0]     in_route_weight,
  input  wire stf_pkg::dp_cmd_t cmd,
  input  wire logic            out_ready,
  output stf_pkg::dp_sts_t     sts,
  output logic [7:0]           ch
);
  import stf_pkg::*;

  logic [1:0]   kind_r;
  logic [127:0] addr_r;
  logic [7:0]   plen_r;
  logic [31:0]  wt_r;
  logic [31:0]  dval_r, dval_nxt;
  logic [3:0]   dig_r [10];
  logic [3:0]   dcnt_r, dcnt_nxt;   // digits stored
  logic [3:0]   epos_r, epos_nxt;   // emit position
  logic [2:0]   scan_r;
  logic [3:0]   cur_len_r, best_len_r;
  logic [2:0]   cur_at_r, best_at_r;
  logic [15:0]  grp;
  logic [7:0]   byte_v;
  logic [1:0]   lead;
  logic [1:0]   gpos;
  logic [3:0]   rem;
  logic [31:0]  quo;
  logic [63:0]  recip;

  assign grp    = addr_r[127 - 16*cmd.idx -: 16];
  assign byte_v = (kind_r == KIND_MAC) ? addr_r[47 - 8*cmd.idx -: 8]
                                       : addr_r[31 - 8*cmd.idx[1:0] -: 8];

  // leading-digit position of group (0..3 skipped)
  always_comb begin
    if (grp[15:12] != 4'd0) lead = 2'd0;
    else if (grp[11:8] != 4'd0) lead = 2'd1;
    else if (grp[7:4] != 4'd0) lead = 2'd2;
    else lead = 2'd3;
  end

  // nibble shown for a group: never before the leading digit
  assign gpos = (epos_r[1:0] < lead) ? lead : epos_r[1:0];

  // divide by 10: reciprocal multiply, exact for all 32-bit values
  always_comb begin
    recip = 64'(dval_r) * 64'(32'hcccc_cccd);
    quo   = {3'd0, recip[63:35]};
    rem   = 4'(dval_r - ((quo << 3) + (quo << 1)));
  end

  always_comb begin
    ch = 8'd0;
    case (cmd.op)
      OP_HEX_BYTE:  ch = hex_ch(epos_r[0] ? byte_v[3:0] : byte_v[7:4]);
      OP_HEX_GROUP: ch = hex_ch(grp[15 - 4*gpos -: 4]);
      OP_DEC_EMIT:  ch = 8'h30 + {4'd0, dig_r[dcnt_r - 4'd1 - epos_r]};
      OP_CHAR:      ch = cmd.lit;
      default:      ch = 8'd0;
    endcase
  end

  always_comb begin
    sts.kind       = kind_r;
    sts.plen_dflt4 = (plen_r == IPV4_FULL_LEN);
    sts.plen_dflt6 = (plen_r == IPV6_FULL_LEN);
    sts.wt_dflt    = (wt_r == WT_DFLT_VAL);
    sts.wt_neg     = wt_r[31];
    sts.run_at     = best_at_r;
    sts.run_len    = best_len_r;
    sts.dec_done   = (dval_r < 32'd10);
    case (cmd.op)
      OP_HEX_BYTE:  sts.char_busy = (epos_r == 4'd0);
      OP_HEX_GROUP: sts.char_busy = (gpos != 2'd3);
      OP_DEC_EMIT:  sts.char_busy = (epos_r != dcnt_r - 4'd1);
      default:      sts.char_busy = 1'b0;
    endcase
  end

  always_comb begin
    epos_nxt = epos_r;
    dval_nxt = dval_r;
    dcnt_nxt = dcnt_r;
    if (cmd.op == OP_DEC_LOAD) begin
      case (cmd.dsrc)
        DSRC_OCTET:  dval_nxt = {24'd0, byte_v};
        DSRC_PLEN:   dval_nxt = {24'd0, plen_r};
        default:     dval_nxt = wt_r[31] ? (32'd0 - wt_r) : wt_r;
      endcase
      dcnt_nxt = 4'd0;
      epos_nxt = 4'd0;
    end else if (cmd.op == OP_DEC_STEP) begin
      dval_nxt = quo;
      dcnt_nxt = dcnt_r + 4'd1;
    end else if (cmd.op == OP_HEX_GROUP && cmd.emit && out_ready) begin
      epos_nxt = sts.char_busy ? {2'd0, gpos} + 4'd1 : 4'd0;
    end else if (cmd.emit && out_ready) begin
      epos_nxt = sts.char_busy ? epos_r + 4'd1 : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      kind_r     <= in_subnet_kind;
      addr_r     <= {in_addr_high, in_addr_low};
      plen_r     <= in_prefix_len;
      wt_r       <= in_route_weight;
      epos_r     <= 4'd0;
      scan_r     <= 3'd0;
      cur_len_r  <= 4'd0;
      best_len_r <= 4'd0;
      cur_at_r   <= 3'd0;
      best_at_r  <= 3'd0;
      dval_r     <= 32'd0;
      dcnt_r     <= 4'd0;
    end else if (cmd.op == OP_FIND_RUN) begin
      scan_r <= scan_r + 3'd1;
      if (addr_r[127 - 16*scan_r -: 16] != 16'd0) begin
        cur_len_r <= 4'd0;
      end else begin
        cur_len_r <= cur_len_r + 4'd1;
        if (cur_len_r == 4'd0) cur_at_r <= scan_r;
        if (cur_len_r + 4'd1 > best_len_r) begin
          best_len_r <= cur_len_r + 4'd1;
          best_at_r  <= (cur_len_r == 4'd0) ? scan_r : cur_at_r;
        end
      end
    end else begin
      if (cmd.op == OP_DEC_STEP) dig_r[dcnt_r] <= rem;
      dval_r <= dval_nxt;
      dcnt_r <= dcnt_nxt;
      epos_r <= epos_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stf_ctrl.sv =====
`default_nettype none
module stf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  out_last_char,
  output logic                  out_bad_kind,
  input  wire stf_pkg::dp_sts_t sts,
  output stf_pkg::dp_cmd_t      cmd
);
  import stf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_ADDR  = 10'b0000000100,
    S_SEP   = 10'b0000001000,
    S_DLOAD = 10'b0000010000,
    S_DSTEP = 10'b0000100000,
    S_DEMIT = 10'b0001000000,
    S_SUFX  = 10'b0010000000,
    S_BAD   = 10'b0100000000,
    S_MINUS = 10'b1000000000
  } state_t;

  // phase of suffix work: 0 address, 1 prefix, 2 weight
  state_t     st_r, st_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       dbl_r, dbl_nxt;     // second ':' of "::"
  logic       after_r, after_nxt; // just printed "::"
  logic       fire;
  logic       more_addr;
  logic       want_plen, want_wt;
  logic [3:0] next_i;

  assign fire = out_valid && out_ready;
  assign want_plen = (sts.kind == KIND_IPV4) ? !sts.plen_dflt4 :
                     (sts.kind == KIND_IPV6) ? !sts.plen_dflt6 : 1'b0;
  assign want_wt = !sts.wt_dflt;

  always_comb begin
    cmd      = '{op: OP_NONE, dsrc: DSRC_OCTET, lit: 8'd0, idx: idx_r, emit: 1'b0};
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    ph_nxt   = ph_r;
    dbl_nxt  = dbl_r;
    after_nxt = after_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_last_char = 1'b0;
    out_bad_kind = 1'b0;
    more_addr = 1'b0;
    next_i = {1'b0, idx_r} + 4'd1;
    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op  = OP_LOAD;
          idx_nxt = 3'd0;
          ph_nxt  = 2'd0;
          dbl_nxt = 1'b0;
          after_nxt = 1'b0;
          st_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        // IPv6 needs eight scan steps; other kinds skip
        if (sts.kind == KIND_BAD) st_nxt = S_BAD;
        else if (sts.kind == KIND_IPV6) begin
          cmd.op = OP_FIND_RUN;
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) st_nxt = S_ADDR;
        end else st_nxt = (sts.kind == KIND_MAC) ? S_ADDR : S_DLOAD;
      end
      S_BAD: begin
        out_valid = 1'b1;
        out_last_char = 1'b1;
        out_bad_kind = 1'b1;
        cmd.op = OP_CHAR;
        cmd.lit = 8'd0;
        if (out_ready) st_nxt = S_IDLE;
      end
      S_ADDR: begin
        if (sts.kind == KIND_MAC) begin
          cmd.op = OP_HEX_BYTE;
          cmd.emit = 1'b1;
          out_valid = 1'b1;
          more_addr = (idx_r != 3'd5);
          out_last_char = !sts.char_busy && !more_addr && !want_wt;
          if (fire && !sts.char_busy) begin
            if (more_addr) begin
              st_nxt = S_SEP;
            end else begin
              ph_nxt = 2'd2;
              st_nxt = want_wt ? S_SUFX : S_IDLE;
            end
          end
        end else if (sts.run_len > 4'd1 && idx_r == sts.run_at) begin
          cmd.op = OP_CHAR;
          cmd.lit = CH_COLON;
          cmd.emit = 1'b1;
          out_valid = 1'b1;
          next_i = {1'b0, idx_r} + sts.run_len;
          out_last_char = dbl_r && next_i[3] && !want_plen && !want_wt;
          if (fire) begin
            if (!dbl_r) dbl_nxt = 1'b1;
            else begin
              dbl_nxt = 1'b0;
              after_nxt = 1'b1;
              if (next_i[3]) begin
                ph_nxt = 2'd1;
                st_nxt = want_plen ? S_SUFX : (want_wt ? S_SUFX : S_IDLE);
                if (!want_plen) ph_nxt = 2'd2;
              end else idx_nxt = next_i[2:0];
            end
          end
        end else if (idx_r != 3'd0 && !after_r && !dbl_r) begin
          cmd.op = OP_CHAR;
          cmd.lit = CH_COLON;
          cmd.emit = 1'b1;
          out_valid = 1'b1;
          if (fire) dbl_nxt = 1'b1; // colon done, reuse flag
        end else begin
          cmd.op = OP_HEX_GROUP;
          cmd.emit = 1'b1;
          out_valid = 1'b1;
          out_last_char = !sts.char_busy && idx_r == 3'd7 && !want_plen && !want_wt;
          if (fire && !sts.char_busy) begin
            dbl_nxt = 1'b0;
            after_nxt = 1'b0;
            if (idx_r == 3'd7) begin
              ph_nxt = want_plen ? 2'd1 : 2'd2;
              st_nxt = (want_plen || want_wt) ? S_SUFX : S_IDLE;
            end else idx_nxt = idx_r + 3'd1;
          end
        end
      end
      S_SEP: begin
        cmd.op = OP_CHAR;
        cmd.lit = (sts.kind == KIND_MAC) ? CH_COLON : CH_DOT;
        cmd.emit = 1'b1;
        out_valid = 1'b1;
        if (fire) begin
          idx_nxt = idx_r + 3'd1;
          st_nxt = (sts.kind == KIND_MAC) ? S_ADDR : S_DLOAD;
        end
      end
      S_SUFX: begin
        cmd.op = OP_CHAR;
        cmd.lit = (ph_r == 2'd1) ? CH_SLASH : CH_HASH;
        cmd.emit = 1'b1;
        out_valid = 1'b1;
        if (fire) st_nxt = (ph_r == 2'd2 && sts.wt_neg) ? S_MINUS : S_DLOAD;
      end
      S_MINUS: begin
        cmd.op = OP_CHAR;
        cmd.lit = CH_MINUS;
        cmd.emit = 1'b1;
        out_valid = 1'b1;
        if (fire) st_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.op = OP_DEC_LOAD;
        cmd.dsrc = (ph_r == 2'd0) ? DSRC_OCTET : (ph_r == 2'd1) ? DSRC_PLEN : DSRC_WEIGHT;
        st_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DEC_STEP;
        if (sts.dec_done) st_nxt = S_DEMIT;
      end
      S_DEMIT: begin
        cmd.op = OP_DEC_EMIT;
        cmd.emit = 1'b1;
        out_valid = 1'b1;
        case (ph_r)
          2'd0:    more_addr = (idx_r != 3'd3) || want_plen || want_wt;
          2'd1:    more_addr = want_wt;
          default: more_addr = 1'b0;
        endcase
        out_last_char = !sts.char_busy && !more_addr;
        if (fire && !sts.char_busy) begin
          if (ph_r == 2'd0 && idx_r != 3'd3) st_nxt = S_SEP;
          else if (ph_r == 2'd0 && want_plen) begin
            ph_nxt = 2'd1; st_nxt = S_SUFX;
          end else if (ph_r != 2'd2 && want_wt) begin
            ph_nxt = 2'd2; st_nxt = S_SUFX;
          end else st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      idx_r <= 3'd0;
      ph_r <= 2'd0;
      dbl_r <= 1'b0;
      after_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      ph_r <= ph_nxt;
      dbl_r <= dbl_nxt;
      after_r <= after_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/subnet_to_text_formatter_unit.sv =====
// Subnet text formatter: one record in, its ASCII text out, one character per item.
// Before the first char: MAC passes the scan state, IPv4 loads its first octet and runs its digit
//   steps, IPv6 runs the zero-run scan over all eight groups.
// Flow: one record at a time; each char waits for out_ready, and each decimal field takes a load
//   and one step per digit; a new record is taken only in idle, after the last char is taken.
// Reset: rst_n synchronous, active low; controller returns to idle, payload not cleared.
`default_nettype none
module subnet_to_text_formatter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_subnet_kind,
  input  wire logic [63:0] in_addr_high,
  input  wire logic [63:0] in_addr_low,
  input  wire logic [7:0]  in_prefix_len,
  input  wire logic signed [31:0] in_route_weight,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_text_char,
  output logic             out_last_char,
  output logic             out_bad_kind
);
  import stf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller sequences the fields; datapath holds the record and converters
  stf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .out_valid,
    .out_last_char, .out_bad_kind, .sts, .cmd
  );

  stf_datapath u_dp (
    .clk, .in_subnet_kind, .in_addr_high, .in_addr_low, .in_prefix_len,
    .in_route_weight(in_route_weight), .cmd, .out_ready, .sts, .ch(out_text_char)
  );

  // a bad kind result is always the lone, last item
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_kind |-> out_last_char) else $error("bad kind not last");
  // no new record while chars are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during output");
  // after the last char is taken the block is idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_char |=> in_ready) else $error("not idle");

endmodule
`default_nettype wire

// ===== dv/subnet_to_text_formatter_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module subnet_to_text_formatter_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_subnet_kind,
  input  wire logic [63:0] in_addr_high,
  input  wire logic [63:0] in_addr_low,
  input  wire logic [7:0]  in_prefix_len,
  input  wire logic [31:0] in_route_weight,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [7:0]  out_text_char,
  input  wire logic        out_last_char,
  input  wire logic        out_bad_kind,
  output int               fail_count,
  output int               pending_chars,
  output int               char_count
);
  import stf_pkg::*;

  // expected char: {bad_kind, last_char, text_char}
  logic [9:0] text_q[$];
  logic [7:0] line_buf[$];

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + d) : (8'h57 + d);
  endfunction

  task automatic push_dec(input logic [31:0] v);
    logic [7:0] dig[$];
    do begin
      dig.push_front(8'h30 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (dig[i]) line_buf.push_back(dig[i]);
  endtask

  task automatic format_record(input logic [1:0] kind, input logic [63:0] hi,
                               input logic [63:0] lo, input logic [7:0] plen,
                               input logic [31:0] wt);
    logic [15:0] grp[8];
    int best_len, best_at, cur_len, cur_at, i;
    logic after_run;
    logic [7:0] b;
    line_buf.delete();
    if (kind == KIND_BAD) begin
      text_q.push_back({1'b1, 1'b1, 8'h00});
      return;
    end
    if (kind == KIND_MAC) begin
      for (i = 0; i < 6; i++) begin
        b = lo[40 - 8*i +: 8];
        if (i > 0) line_buf.push_back(CH_COLON);
        line_buf.push_back(hex_digit(b[7:4]));
        line_buf.push_back(hex_digit(b[3:0]));
      end
    end else if (kind == KIND_IPV4) begin
      for (i = 0; i < 4; i++) begin
        if (i > 0) line_buf.push_back(CH_DOT);
        push_dec({24'd0, lo[24 - 8*i +: 8]});
      end
      if (plen != IPV4_FULL_LEN) begin
        line_buf.push_back(CH_SLASH);
        push_dec({24'd0, plen});
      end
    end else begin
      for (i = 0; i < 8; i++) grp[i] = (i < 4) ? hi[48 - 16*i +: 16] : lo[48 - 16*(i-4) +: 16];
      best_len = 0; best_at = 0; cur_len = 0; cur_at = 0;
      for (i = 0; i < 8; i++) begin
        if (grp[i] != 0) cur_len = 0;
        else begin
          if (cur_len == 0) cur_at = i;
          cur_len++;
          if (cur_len > best_len) begin
            best_len = cur_len;
            best_at = cur_at;
          end
        end
      end
      i = 0;
      after_run = 0;
      while (i < 8) begin
        if (best_len > 1 && i == best_at) begin
          line_buf.push_back(CH_COLON);
          line_buf.push_back(CH_COLON);
          i += best_len;
          after_run = 1;
        end else begin
          if (i > 0 && !after_run) line_buf.push_back(CH_COLON);
          begin
            logic started;
            started = 0;
            for (int s = 12; s >= 0; s -= 4) begin
              if (grp[i][s +: 4] != 0 || started || s == 0) begin
                line_buf.push_back(hex_digit(grp[i][s +: 4]));
                started = 1;
              end
            end
          end
          after_run = 0;
          i++;
        end
      end
      if (plen != IPV6_FULL_LEN) begin
        line_buf.push_back(CH_SLASH);
        push_dec({24'd0, plen});
      end
    end
    if (wt != WT_DFLT_VAL) begin
      line_buf.push_back(CH_HASH);
      if (wt[31]) begin
        line_buf.push_back(CH_MINUS);
        push_dec(32'd0 - wt);
      end else push_dec(wt);
    end
    foreach (line_buf[k]) text_q.push_back({1'b0, (k == line_buf.size() - 1), line_buf[k]});
  endtask

  assign pending_chars = text_q.size();

  always @(posedge clk) begin
    logic [9:0] exp_c;
    if (!rst_n) begin
      fail_count <= 0;
      char_count <= 0;
    end else begin
      if (in_valid && in_ready)
        format_record(in_subnet_kind, in_addr_high, in_addr_low, in_prefix_len, in_route_weight);
      if (out_valid && out_ready) begin
        char_count <= char_count + 1;
        if (text_q.size() == 0) begin
          $display("%0t unexpected char: actual %h last %b bad %b", $time,
                   out_text_char, out_last_char, out_bad_kind);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = text_q.pop_front();
          if (exp_c != {out_bad_kind, out_last_char, out_text_char}) begin
            $display("%0t char mismatch: expected %h/%b/%b actual %h/%b/%b", $time,
                     exp_c[7:0], exp_c[8], exp_c[9], out_text_char, out_last_char,
                     out_bad_kind);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/subnet_to_text_formatter_unit_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module subnet_to_text_formatter_unit_test;
  import stf_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_subnet_kind = '0;
  logic [63:0] in_addr_high = '0;
  logic [63:0] in_addr_low = '0;
  logic [7:0]  in_prefix_len = '0;
  logic signed [31:0] in_route_weight = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_text_char;
  logic        out_last_char;
  logic        out_bad_kind;
  int          fail_count, pending_chars, char_count;

  // idle probabilities in percent, changed per phase
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;     // long receiver hold-off for back-pressure
  int records_sent = 0;
  int quiet_cycles = 0;
  localparam int QUIET_LIMIT = 20000;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  subnet_to_text_formatter_unit dut (.*);

  subnet_to_text_formatter_checker chk (.*);

  // receiver: random stall unless the hold-off is on
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // watchdog on accept activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // offer one record and hold it until accepted
  task automatic send_record(input logic [1:0] k, input logic [63:0] hi, input logic [63:0] lo,
                             input logic [7:0] pl, input logic [31:0] wt);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid        <= 1;
    in_subnet_kind  <= k;
    in_addr_high    <= hi;
    in_addr_low     <= lo;
    in_prefix_len   <= pl;
    in_route_weight <= wt;
    do @(posedge clk); while (!in_ready);
    records_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // IPv6 word with random zero groups so that runs and ties show up
  function automatic logic [63:0] sparse64();
    logic [63:0] w;
    w = rand64();
    for (int g = 0; g < 4; g++) begin
      if ($urandom_range(1)) w[16*g +: 16] = 0;
      else if ($urandom_range(3) == 0) w[16*g +: 16] = 16'($urandom_range(15));
    end
    return w;
  endfunction

  task automatic send_random();
    logic [1:0] k;
    logic [7:0] pl;
    logic [31:0] wt;
    k = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: pl = (k == KIND_IPV6) ? IPV6_FULL_LEN : IPV4_FULL_LEN;
      1: pl = 8'($urandom_range(128));
      default: pl = 8'($urandom());
    endcase
    case ($urandom_range(4))
      0: wt = WT_DFLT_VAL;
      1: wt = 32'($urandom_range(100));
      2: wt = 32'd0 - 32'($urandom_range(100));
      default: wt = $urandom();
    endcase
    send_record(k, (k == KIND_IPV6) ? sparse64() : rand64(),
                (k == KIND_IPV6) ? sparse64() : rand64(), pl, wt);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes of each kind, run rules, weight corners
    send_record(KIND_MAC, '0, '0, 8'd0, WT_DFLT_VAL);
    send_record(KIND_MAC, '1, '1, 8'd255, 32'h8000_0000);
    send_record(KIND_MAC, '0, 64'h0000_0a1b_2c3d_4e5f, 8'd7, 32'd0);
    send_record(KIND_IPV4, '0, '0, IPV4_FULL_LEN, WT_DFLT_VAL);
    send_record(KIND_IPV4, '1, '1, 8'd255, 32'h7fff_ffff);
    send_record(KIND_IPV4, '0, 64'h0a00_6405, 8'd0, 32'hffff_ffff);
    send_record(KIND_IPV4, '0, 64'hc0a8_0101, 8'd24, 32'd9);
    send_record(KIND_IPV6, '0, '0, IPV6_FULL_LEN, WT_DFLT_VAL);
    send_record(KIND_IPV6, '1, '1, 8'd255, 32'h8000_0000);
    send_record(KIND_IPV6, 64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0001, 8'd64,
                WT_DFLT_VAL);
    send_record(KIND_IPV6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007, 8'd128, 32'd11);
    send_record(KIND_IPV6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004, 8'd48, 32'd10);
    send_record(KIND_IPV6, 64'h0000_0000_0001_0002, 64'h0003_0000_0000_0000, 8'd100, 32'd1);
    send_record(KIND_IPV6, 64'h0001_0000_0000_0002, 64'h0003_0000_0000_0004, 8'd127, 32'd0);
    send_record(KIND_IPV6, 64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001, 8'd129, 32'd12);
    send_record(KIND_IPV6, 64'h00ab_0f00_1000_0000, 64'h0000_0000_0000_0000, 8'd32, 32'd10);
    send_record(KIND_BAD, '1, '1, 8'd255, 32'd5);
    send_record(KIND_BAD, '0, '0, 8'd0, WT_DFLT_VAL);

    // random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      repeat (24) send_random();
    end

    // back-pressure: receiver holds off while records keep coming
    send_idle = 0;
    recv_stall = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (6) send_random();
    join
    in_valid <= 0;

    while (pending_chars != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d records (MAC, IPv4, IPv6, bad kind), checked %0d chars", records_sent,
             char_count);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
